// ----- rtl/mrt_pkg.sv -----
// mrt_pkg: shared types and constants for the 4x4 matrix row transform core.
// No dependencies.
`timescale 1ns / 1ps

package mrt_pkg;

  localparam int ELEM_W = 32;
  localparam int PROD_W = 2 * ELEM_W;
  localparam int PAIR_W = PROD_W + 1;
  localparam int SUM_W  = PROD_W + 2;
  localparam int DIM    = 4;

  typedef enum logic [1:0] {
    FUNC_LOAD_ROW   = 2'd0,
    FUNC_LOAD_XLATE = 2'd1,
    FUNC_MUL_ROW    = 2'd2
  } func_t;

  typedef struct packed {
    logic ld1;
    logic ld2;
  } lane_ctl_t;

endpackage

// ----- rtl/mrt_lane.sv -----
// mrt_lane: one result column; four products, pairwise sums, final sum.
// Depends on mrt_pkg.
`timescale 1ns / 1ps

module mrt_lane (
  input  logic                             clk,
  input  mrt_pkg::lane_ctl_t               ctl,
  input  logic signed [mrt_pkg::ELEM_W-1:0] lhs [mrt_pkg::DIM],
  input  logic signed [mrt_pkg::ELEM_W-1:0] col [mrt_pkg::DIM],
  output logic signed [mrt_pkg::SUM_W-1:0]  sum
);

  logic signed [mrt_pkg::PROD_W-1:0] prod [mrt_pkg::DIM];
  logic signed [mrt_pkg::PAIR_W-1:0] pair [2];

  always_ff @(posedge clk) begin
    if (ctl.ld1) begin
      for (int k = 0; k < mrt_pkg::DIM; k++) begin
        prod[k] <= lhs[k] * col[k];
      end
    end
    if (ctl.ld2) begin
      pair[0] <= mrt_pkg::PAIR_W'(prod[0]) + mrt_pkg::PAIR_W'(prod[1]);
      pair[1] <= mrt_pkg::PAIR_W'(prod[2]) + mrt_pkg::PAIR_W'(prod[3]);
    end
  end

  assign sum = mrt_pkg::SUM_W'(pair[0]) + mrt_pkg::SUM_W'(pair[1]);

endmodule

// ----- rtl/mrt_merge.sv -----
// mrt_merge: shifts and saturates the lane sums, merges clip flags,
// and holds the output register. Depends on mrt_pkg.
`timescale 1ns / 1ps

module mrt_merge #(
  parameter int FRAC_BITS   = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              ld,
  input  logic [1:0]                        row_in,
  input  logic signed [mrt_pkg::SUM_W-1:0]  sums [mrt_pkg::DIM],
  output logic [1:0]                        out_row,
  output logic signed [mrt_pkg::ELEM_W-1:0] out_col [mrt_pkg::DIM],
  output logic                              saturated
);

  localparam logic signed [mrt_pkg::SUM_W-1:0] MAXV =
    (mrt_pkg::SUM_W'(1) <<< (VALUE_WIDTH - 1)) - mrt_pkg::SUM_W'(1);
  localparam logic signed [mrt_pkg::SUM_W-1:0] MINV = -MAXV - mrt_pkg::SUM_W'(1);

  logic signed [mrt_pkg::SUM_W-1:0]  shifted [mrt_pkg::DIM];
  logic signed [mrt_pkg::SUM_W-1:0]  clipped [mrt_pkg::DIM];
  logic [mrt_pkg::DIM-1:0]           clip;

  always_comb begin
    for (int j = 0; j < mrt_pkg::DIM; j++) begin
      shifted[j] = sums[j] >>> FRAC_BITS;
      clip[j]    = 1'b1;
      if (shifted[j] > MAXV) begin
        clipped[j] = MAXV;
      end else if (shifted[j] < MINV) begin
        clipped[j] = MINV;
      end else begin
        clipped[j] = shifted[j];
        clip[j]    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      out_row   <= row_in;
      saturated <= |clip;
      for (int j = 0; j < mrt_pkg::DIM; j++) begin
        out_col[j] <= clipped[j][mrt_pkg::ELEM_W-1:0];
      end
    end
  end

endmodule

// ----- rtl/matrix4_row_transform_core.sv -----
// Pipeline: out_valid rises once an accepted multiply transaction has passed the
// product, pair-sum and output registers; a stall on out_ready can hold it on the way.
// Throughput: one transaction per cycle; in_ready is low only while all three
// stages hold a row and out_ready is low. Loads take effect at accept.
// Stages: 16 32x32 products, pair sums, final sum/shift/saturate into the
// output register. Reset loads identity. Depends on mrt_pkg, mrt_lane, mrt_merge.
`timescale 1ns / 1ps

module matrix4_row_transform_core #(
  parameter int FRAC_BITS   = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         func,
  input  logic [1:0]         row_sel,
  input  logic signed [31:0] elem_0,
  input  logic signed [31:0] elem_1,
  input  logic signed [31:0] elem_2,
  input  logic signed [31:0] elem_3,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_row,
  output logic signed [31:0] out_0,
  output logic signed [31:0] out_1,
  output logic signed [31:0] out_2,
  output logic signed [31:0] out_3,
  output logic               saturated
);

  localparam logic [mrt_pkg::ELEM_W-1:0] ONE = mrt_pkg::ELEM_W'(1) << FRAC_BITS;

  logic [mrt_pkg::ELEM_W-1:0]        mat [16];
  logic signed [mrt_pkg::ELEM_W-1:0] lhs [mrt_pkg::DIM];
  logic signed [mrt_pkg::SUM_W-1:0]  lane_sum [mrt_pkg::DIM];
  logic signed [mrt_pkg::ELEM_W-1:0] res [mrt_pkg::DIM];
  mrt_pkg::lane_ctl_t                ctl;

  logic       v1, v2, v3;
  logic       ld3;
  logic [1:0] row1, row2;
  logic       accept;

  assign ld3     = !v3 || out_ready;
  assign ctl.ld2 = !v2 || ld3;
  assign ctl.ld1 = !v1 || ctl.ld2;
  assign in_ready = ctl.ld1;
  assign accept   = in_valid && in_ready;
  assign out_valid = v3;

  assign lhs[0] = elem_0;
  assign lhs[1] = elem_1;
  assign lhs[2] = elem_2;
  assign lhs[3] = elem_3;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) begin
        mat[i] <= (i % 5 == 0) ? ONE : '0;
      end
    end else if (accept) begin
      case (func)
        mrt_pkg::FUNC_LOAD_ROW: begin
          for (int i = 0; i < mrt_pkg::DIM; i++) begin
            mat[{row_sel, 2'(i)}] <= lhs[i];
          end
        end
        mrt_pkg::FUNC_LOAD_XLATE: begin
          for (int i = 0; i < 16; i++) begin
            if (i == 3)       mat[i] <= elem_0;
            else if (i == 7)  mat[i] <= elem_1;
            else if (i == 11) mat[i] <= elem_2;
            else              mat[i] <= (i % 5 == 0) ? ONE : '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ctl.ld1) v1 <= accept && (func == mrt_pkg::FUNC_MUL_ROW);
      if (ctl.ld2) v2 <= v1;
      if (ld3)     v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld1) row1 <= row_sel;
    if (ctl.ld2) row2 <= row1;
  end

  for (genvar j = 0; j < mrt_pkg::DIM; j++) begin : g_lane
    logic signed [mrt_pkg::ELEM_W-1:0] col [mrt_pkg::DIM];
    for (genvar k = 0; k < mrt_pkg::DIM; k++) begin : g_col
      assign col[k] = mat[k * 4 + j];
    end
    mrt_lane u_lane (
      .clk (clk),
      .ctl (ctl),
      .lhs (lhs),
      .col (col),
      .sum (lane_sum[j])
    );
  end

  mrt_merge #(
    .FRAC_BITS   (FRAC_BITS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_merge (
    .clk       (clk),
    .ld        (ld3),
    .row_in    (row2),
    .sums      (lane_sum),
    .out_row   (out_row),
    .out_col   (res),
    .saturated (saturated)
  );

  assign out_0 = res[0];
  assign out_1 = res[1];
  assign out_2 = res[2];
  assign out_3 = res[3];

endmodule
